// ===== rtl/mda_pkg.sv =====
// Shared types and constants of the motion delta accumulator.
package mda_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned NUM_SLOTS  = 3;
    localparam int unsigned CNT_W      = 2;

    localparam logic [8:0]         SHUTTER_LIMIT = 9'd45;
    localparam logic [15:0]        SMART_REG     = 16'h0032;
    localparam logic signed [15:0] SMART_ON_VAL  = 16'sh0080;

    typedef enum logic [KIND_W-1:0] {
        KIND_X         = 3'd0,
        KIND_Y         = 3'd1,
        KIND_SMART_OFF = 3'd2,
        KIND_SMART_ON  = 3'd3,
        KIND_BUSY      = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_READY = 3'd0,
        CFG_REPORT_IVL   = 3'd1,
        CFG_SMART_EN     = 3'd2,
        CFG_EVENT_TYPE   = 3'd3,
        CFG_X_CODE       = 3'd4,
        CFG_Y_CODE       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        sensor_ready;
        logic [15:0] report_interval_ms;
        logic        smart_enable;
        logic [7:0]  event_type;
        logic [15:0] x_code;
        logic [15:0] y_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  x_low;
        logic [7:0]  y_low;
        logic [7:0]  xy_high;
        logic [8:0]  shutter;
        logic [31:0] now_ms;
    } t_sample;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         event_tag;
        logic [15:0]        code;
        logic signed [15:0] value;
        logic               sync;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]              count;
        t_result [NUM_SLOTS-1:0]       res;
    } t_bundle;

endpackage

// ===== rtl/mda_ifs.sv =====
// Handshake channel interfaces for samples, results and configuration writes.
interface mda_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  x_low;
    logic [7:0]  y_low;
    logic [7:0]  xy_high;
    logic [8:0]  shutter;
    logic [31:0] now_ms;

    modport source (output valid, x_low, y_low, xy_high, shutter, now_ms, input ready);
    modport sink   (input valid, x_low, y_low, xy_high, shutter, now_ms, output ready);
endinterface

interface mda_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         event_tag;
    logic [15:0]        code;
    logic signed [15:0] value;
    logic               sync;
    logic               last;

    modport source (output valid, kind, event_tag, code, value, sync, last, input ready);
    modport sink   (input valid, kind, event_tag, code, value, sync, last, output ready);
endinterface

interface mda_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mda_in_stage.sv =====
// Input register that holds one accepted sample for the compute stage.
module mda_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mda_in_if.sink           i_in,
    input  logic             i_take,
    output logic             o_valid,
    output mda_pkg::t_sample o_sample
);
    import mda_pkg::*;

    logic    r_valid;
    t_sample r_sample;
    logic    accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_sample   = r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample.x_low   <= i_in.x_low;
            r_sample.y_low   <= i_in.y_low;
            r_sample.xy_high <= i_in.xy_high;
            r_sample.shutter <= i_in.shutter;
            r_sample.now_ms  <= i_in.now_ms;
        end
    end

endmodule

// ===== rtl/mda_core.sv =====
// Accumulator state and the single-pass computation of one sample's results.
module mda_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mda_pkg::t_cfg    i_cfg,
    input  logic             i_fire,
    input  mda_pkg::t_sample i_sample,
    output mda_pkg::t_bundle o_bundle
);
    import mda_pkg::*;

    logic signed [31:0] r_sum_x;
    logic signed [31:0] r_sum_y;
    logic [31:0]        r_last_sample;
    logic [31:0]        r_last_report;
    logic               r_smart;

    logic signed [31:0] n_sum_x;
    logic signed [31:0] n_sum_y;
    logic               n_smart;

    logic signed [11:0] dx;
    logic signed [11:0] dy;
    logic               ivl_on;
    logic [31:0]        ivl_ext;
    logic [31:0]        dt_sample;
    logic [31:0]        dt_report;
    logic               purge;
    logic               gate_ok;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic               report;
    logic               smart_off;
    logic               smart_on;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [11:0] b);
        logic signed [32:0] t;
        t = {a[31], a} + {{21{b[11]}}, b};
        if (t[32] != t[31]) begin
            sat_add = t[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_add = t[31:0];
        end
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [31:0] v);
        if (!v[31] && (|v[30:15])) begin
            clamp16 = 16'sh7FFF;
        end else if (v[31] && !(&v[30:15])) begin
            clamp16 = 16'sh8000;
        end else begin
            clamp16 = v[15:0];
        end
    endfunction

    assign dx        = {i_sample.xy_high[7:4], i_sample.x_low};
    assign dy        = {i_sample.xy_high[3:0], i_sample.y_low};
    assign ivl_on    = (i_cfg.report_interval_ms != 16'd0);
    assign ivl_ext   = {16'd0, i_cfg.report_interval_ms};
    assign dt_sample = i_sample.now_ms - r_last_sample;
    assign dt_report = i_sample.now_ms - r_last_report;
    assign purge     = ivl_on && (dt_sample >= ivl_ext);
    assign gate_ok   = !ivl_on || (dt_report >= ivl_ext);
    assign base_x    = purge ? 32'sd0 : r_sum_x;
    assign base_y    = purge ? 32'sd0 : r_sum_y;
    assign acc_x     = sat_add(base_x, dx);
    assign acc_y     = sat_add(base_y, dy);
    assign rx        = clamp16(acc_x);
    assign ry        = clamp16(acc_y);
    assign report    = gate_ok && ((rx != 16'sd0) || (ry != 16'sd0));
    assign n_sum_x   = report ? 32'sd0 : acc_x;
    assign n_sum_y   = report ? 32'sd0 : acc_y;

    assign smart_off = i_cfg.smart_enable && r_smart && (i_sample.shutter < SHUTTER_LIMIT);
    assign smart_on  = i_cfg.smart_enable && !r_smart && (i_sample.shutter > SHUTTER_LIMIT);
    assign n_smart   = smart_on ? 1'b1 : (smart_off ? 1'b0 : r_smart);

    always_comb begin
        logic [CNT_W-1:0] n;
        n        = '0;
        o_bundle = '0;
        if (!i_cfg.sensor_ready) begin
            o_bundle.res[0].kind = KIND_BUSY;
            n = 2'd1;
        end else begin
            if (smart_off) begin
                o_bundle.res[n].kind = KIND_SMART_OFF;
                o_bundle.res[n].code = SMART_REG;
                n = n + 2'd1;
            end
            if (smart_on) begin
                o_bundle.res[n].kind  = KIND_SMART_ON;
                o_bundle.res[n].code  = SMART_REG;
                o_bundle.res[n].value = SMART_ON_VAL;
                n = n + 2'd1;
            end
            if (report && (rx != 16'sd0)) begin
                o_bundle.res[n].kind      = KIND_X;
                o_bundle.res[n].event_tag = i_cfg.event_type;
                o_bundle.res[n].code      = i_cfg.x_code;
                o_bundle.res[n].value     = rx;
                o_bundle.res[n].sync      = (ry == 16'sd0);
                n = n + 2'd1;
            end
            if (report && (ry != 16'sd0)) begin
                o_bundle.res[n].kind      = KIND_Y;
                o_bundle.res[n].event_tag = i_cfg.event_type;
                o_bundle.res[n].code      = i_cfg.y_code;
                o_bundle.res[n].value     = ry;
                o_bundle.res[n].sync      = 1'b1;
                n = n + 2'd1;
            end
        end
        if (n != 2'd0) begin
            o_bundle.res[n - 2'd1].last = 1'b1;
        end
        o_bundle.count = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x       <= '0;
            r_sum_y       <= '0;
            r_last_sample <= '0;
            r_last_report <= '0;
            r_smart       <= 1'b0;
        end else if (i_fire && i_cfg.sensor_ready) begin
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_smart <= n_smart;
            if (ivl_on) begin
                r_last_sample <= i_sample.now_ms;
            end
            if (ivl_on && report) begin
                r_last_report <= i_sample.now_ms;
            end
        end
    end

endmodule

// ===== rtl/mda_out_queue.sv =====
// Three-slot result register that sends one word per cycle while the receiver is ready.
module mda_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mda_pkg::t_bundle i_bundle,
    output logic             o_free,
    mda_out_if.source        o_out
);
    import mda_pkg::*;

    t_result [NUM_SLOTS-1:0] r_slot;
    logic [CNT_W-1:0]        r_cnt;
    logic                    pop;

    assign pop    = (r_cnt != 2'd0) && o_out.ready;
    assign o_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.kind      = r_slot[0].kind;
    assign o_out.event_tag = r_slot[0].event_tag;
    assign o_out.code      = r_slot[0].code;
    assign o_out.value     = r_slot[0].value;
    assign o_out.sync      = r_slot[0].sync;
    assign o_out.last      = r_slot[0].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_bundle.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_bundle.res;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

// ===== rtl/motion_delta_accumulator.sv =====
// Top level of the motion delta accumulator: config registers and stage wiring.
// An accepted sample waits in the input register until the result register can take its words.
// Throughput: one sample per cycle while each yields at most one result word and o_out is ready;
// else the next waits while the result register drains up to three words, one a cycle when ready.
// Reset is synchronous and active low: sums, timestamps and the smart flag clear to zero,
// configuration registers return to their defaults and no result word is pending.
module motion_delta_accumulator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mda_in_if.sink    i_in,
    mda_out_if.source o_out,
    mda_cfg_if.sink   i_cfg
);
    import mda_pkg::*;

    t_cfg    r_cfg;
    logic    in_valid;
    t_sample in_sample;
    t_bundle bundle;
    logic    q_free;
    logic    fire;

    assign i_cfg.ready = 1'b1;
    assign fire        = in_valid && q_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_ready       <= 1'b0;
            r_cfg.report_interval_ms <= 16'd0;
            r_cfg.smart_enable       <= 1'b0;
            r_cfg.event_type         <= 8'd2;
            r_cfg.x_code             <= 16'd0;
            r_cfg.y_code             <= 16'd1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_SENSOR_READY: begin
                    r_cfg.sensor_ready <= i_cfg.data[0];
                end
                CFG_REPORT_IVL: begin
                    r_cfg.report_interval_ms <= i_cfg.data;
                end
                CFG_SMART_EN: begin
                    r_cfg.smart_enable <= i_cfg.data[0];
                end
                CFG_EVENT_TYPE: begin
                    r_cfg.event_type <= i_cfg.data[7:0];
                end
                CFG_X_CODE: begin
                    r_cfg.x_code <= i_cfg.data;
                end
                CFG_Y_CODE: begin
                    r_cfg.y_code <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    mda_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_take   (fire),
        .o_valid  (in_valid),
        .o_sample (in_sample)
    );

    mda_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_fire   (fire),
        .i_sample (in_sample),
        .o_bundle (bundle)
    );

    mda_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_bundle (bundle),
        .o_free   (q_free),
        .o_out    (o_out)
    );

endmodule

// ===== rtl/mda_checker.sv =====
// Port-level checks of the motion delta accumulator and their binding.
module mda_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [7:0]  i_event_tag,
    input logic [15:0] i_code,
    input logic [15:0] i_value,
    input logic        i_sync,
    input logic        i_last
);
    import mda_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_code)
            && $stable(i_value) && $stable(i_last))
        else $error("result word changed while stalled");

    a_busy_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_BUSY) |-> i_last && (i_code == 16'd0)
            && (i_value == 16'd0) && (i_event_tag == 8'd0) && !i_sync)
        else $error("malformed busy word");

    a_smart_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_kind == KIND_SMART_OFF) || (i_kind == KIND_SMART_ON))
            |-> (i_code == SMART_REG) && (i_event_tag == 8'd0) && !i_sync)
        else $error("malformed smart register write");

    a_x_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_X) && !i_sync |-> !i_last)
        else $error("open X report ended the sample");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result word pending right after reset");

endmodule

bind motion_delta_accumulator mda_checker u_mda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_event_tag (o_out.event_tag),
    .i_code      (o_out.code),
    .i_value     (o_out.value),
    .i_sync      (o_out.sync),
    .i_last      (o_out.last)
);

// ===== verif/motion_delta_accumulator_tb.sv =====
// Self-checking testbench for the motion delta accumulator: directed and random samples.
`timescale 1ns / 1ps

module motion_delta_accumulator_tb;
    import mda_pkg::*;

    localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;
    localparam int         RUN_LIMIT_NS   = 2_000_000;
    localparam longint     SUM_MAX        = 64'sd2147483647;
    localparam longint     SUM_MIN        = -64'sd2147483648;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mda_in_if  in_if ();
    mda_out_if out_if ();
    mda_cfg_if cfg_if ();

    motion_delta_accumulator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #6 i_clk = ~i_clk;

    logic        cur_ready    = 1'b0;
    logic [15:0] cur_ivl      = 16'd0;
    logic        cur_smart_en = 1'b0;
    logic [7:0]  cur_evt      = 8'd2;
    logic [15:0] cur_xc       = 16'd0;
    logic [15:0] cur_yc       = 16'd1;

    int          acc_x       = 0;
    int          acc_y       = 0;
    logic [31:0] seen_ms     = 32'd0;
    logic [31:0] reported_ms = 32'd0;
    logic        smart_on    = 1'b0;

    t_sample     sample_q[$];
    t_result     report_q[$];
    int          issued     = 0;
    int          accepted   = 0;
    int          mismatches = 0;
    bit          steady     = 1'b0;
    logic [31:0] clock_ms;

    function automatic t_result word_of(t_kind k, logic [7:0] tag, logic [15:0] code,
                                        logic signed [15:0] v, logic s);
        t_result r;
        r.kind      = k;
        r.event_tag = tag;
        r.code      = code;
        r.value     = v;
        r.sync      = s;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic int sat_sum(int a, logic signed [11:0] d);
        longint t;
        t = longint'(a) + longint'(d);
        if (t > SUM_MAX) t = SUM_MAX;
        if (t < SUM_MIN) t = SUM_MIN;
        return int'(t);
    endfunction

    function automatic int clamp_word(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic string show(t_result r);
        return $sformatf("kind=%0d tag=%0d code=%0d value=%0d sync=%0d last=%0d",
                         r.kind, r.event_tag, r.code, r.value, r.sync, r.last);
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // Computes the words that one accepted sample should produce and advances the shadow state.
    function automatic void predict_sample(logic [7:0] xl, logic [7:0] yl, logic [7:0] xyh,
                                           logic [8:0] shut, logic [31:0] now);
        t_result            words[$];
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        int                 rx;
        int                 ry;
        if (!cur_ready) begin
            words.push_back(word_of(KIND_BUSY, 8'd0, 16'd0, 16'sd0, 1'b0));
        end else begin
            dx = {xyh[7:4], xl};
            dy = {xyh[3:0], yl};
            if (cur_smart_en) begin
                if (smart_on && shut < SHUTTER_LIMIT) begin
                    words.push_back(word_of(KIND_SMART_OFF, 8'd0, SMART_REG, 16'sd0, 1'b0));
                    smart_on = 1'b0;
                end
                if (!smart_on && shut > SHUTTER_LIMIT) begin
                    words.push_back(word_of(KIND_SMART_ON, 8'd0, SMART_REG, SMART_ON_VAL, 1'b0));
                    smart_on = 1'b1;
                end
            end
            if (cur_ivl != 16'd0) begin
                if (now - seen_ms >= {16'd0, cur_ivl}) begin
                    acc_x = 0;
                    acc_y = 0;
                end
                seen_ms = now;
            end
            acc_x = sat_sum(acc_x, dx);
            acc_y = sat_sum(acc_y, dy);
            if (cur_ivl == 16'd0 || now - reported_ms >= {16'd0, cur_ivl}) begin
                rx = clamp_word(acc_x);
                ry = clamp_word(acc_y);
                if (rx != 0 || ry != 0) begin
                    if (cur_ivl != 16'd0) reported_ms = now;
                    acc_x = 0;
                    acc_y = 0;
                    if (rx != 0) words.push_back(word_of(KIND_X, cur_evt, cur_xc, 16'(rx), ry == 0));
                    if (ry != 0) words.push_back(word_of(KIND_Y, cur_evt, cur_yc, 16'(ry), 1'b1));
                end
            end
        end
        if (words.size() > 0) words[words.size() - 1].last = 1'b1;
        foreach (words[i]) report_q.push_back(words[i]);
    endfunction

    function automatic void add_sample(int dx, int dy, int unsigned shut, logic [31:0] now);
        t_sample    s;
        logic [11:0] ux;
        logic [11:0] uy;
        ux        = dx[11:0];
        uy        = dy[11:0];
        s.x_low   = ux[7:0];
        s.y_low   = uy[7:0];
        s.xy_high = {ux[11:8], uy[11:8]};
        s.shutter = shut[8:0];
        s.now_ms  = now;
        sample_q.push_back(s);
        issued++;
    endfunction

    function automatic void add_random_sample(logic [31:0] now);
        int          dx;
        int          dy;
        int unsigned shut;
        case ($urandom_range(9))
            0: begin
                dx = 0;
                dy = 0;
            end
            1, 2, 3, 4: begin
                dx = int'($urandom_range(40)) - 20;
                dy = int'($urandom_range(40)) - 20;
            end
            default: begin
                dx = int'($urandom);
                dy = int'($urandom);
            end
        endcase
        shut = $urandom_range(1) ? $urandom_range(50, 40) : $urandom_range(511);
        add_sample(dx, dy, shut, now);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_SENSOR_READY: cur_ready    = val[0];
            CFG_REPORT_IVL:   cur_ivl      = val;
            CFG_SMART_EN:     cur_smart_en = val[0];
            CFG_EVENT_TYPE:   cur_evt      = val[7:0];
            CFG_X_CODE:       cur_xc       = val;
            CFG_Y_CODE:       cur_yc       = val;
            default: ;
        endcase
    endtask

    // The upper data bits of the narrow registers are randomized to exercise the width masking.
    task automatic configure(input logic rdy, input logic [15:0] ivl, input logic smart,
                             input logic [7:0] evt, input logic [15:0] xc, input logic [15:0] yc);
        write_reg(CFG_SENSOR_READY, {15'($urandom), rdy});
        write_reg(CFG_REPORT_IVL, ivl);
        write_reg(CFG_SMART_EN, {15'($urandom), smart});
        write_reg(CFG_EVENT_TYPE, {8'($urandom), evt});
        write_reg(CFG_X_CODE, xc);
        write_reg(CFG_Y_CODE, yc);
        write_reg(CFG_IDX_UNUSED, 16'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic settle();
        @(posedge i_clk);
        while (accepted != issued || report_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_sample nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_sample(in_if.x_low, in_if.y_low, in_if.xy_high, in_if.shutter,
                               in_if.now_ms);
                accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (sample_q.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
                    nxt = sample_q.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.x_low   <= nxt.x_low;
                    in_if.y_low   <= nxt.y_low;
                    in_if.xy_high <= nxt.xy_high;
                    in_if.shutter <= nxt.shutter;
                    in_if.now_ms  <= nxt.now_ms;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= steady || ($urandom_range(99) >= 17);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.kind      = t_kind'(out_if.kind);
            got.event_tag = out_if.event_tag;
            got.code      = out_if.code;
            got.value     = out_if.value;
            got.sync      = out_if.sync;
            got.last      = out_if.last;
            if (report_q.size() == 0) begin
                log_mismatch({"unexpected word: ", show(got)});
            end else begin
                want = report_q.pop_front();
                if (got !== want) begin
                    log_mismatch({"expected ", show(want), " got ", show(got)});
                end
            end
        end
    end

    initial begin
        in_if.valid   = 1'b0;
        in_if.x_low   = 8'd0;
        in_if.y_low   = 8'd0;
        in_if.xy_high = 8'd0;
        in_if.shutter = 9'd0;
        in_if.now_ms  = 32'd0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = 3'd0;
        cfg_if.data   = 16'd0;
        i_rst_n       = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the sensor is not ready, so every word is busy.
        repeat (3) add_random_sample($urandom);
        settle();

        configure(1'b1, 16'd0, 1'b1, 8'hFF, 16'hFFFF, 16'h0000);
        add_sample(2047, 0, 0, 32'd0);
        add_sample(0, -2048, 46, 32'hFFFF_FFFF);
        add_sample(-2048, 2047, 45, 32'd7);
        add_sample(0, 0, 44, 32'd7);
        add_sample(0, 0, 45, 32'd8);
        add_sample(1, -1, 511, 32'd9);
        add_sample(0, 0, 0, 32'd10);
        settle();

        // Small time steps keep the sums alive until the interval opens, well past 16 bits.
        configure(1'b1, 16'd17, 1'b0, 8'h00, 16'h0000, 16'hFFFF);
        for (int k = 0; k <= 17; k++) add_sample(2047, -2048, $urandom_range(511), 32'd1000 + k);
        add_sample(5, 0, $urandom_range(511), 32'hFFFF_FFF8);
        add_sample(0, -3, $urandom_range(511), 32'h0000_0009);
        settle();

        configure(1'b1, 16'($urandom_range(8, 1)), 1'b1, 8'($urandom), 16'($urandom),
                  16'($urandom));
        clock_ms = $urandom;
        repeat (25) begin
            if ($urandom_range(9) == 0) clock_ms = $urandom;
            else clock_ms += $urandom_range(10);
            add_random_sample(clock_ms);
        end
        settle();

        steady = 1'b1;
        configure(1'b1, 16'hFFFF, 1'b1, 8'($urandom), 16'($urandom), 16'($urandom));
        repeat (20) begin
            if ($urandom_range(9) == 0) clock_ms = $urandom;
            else clock_ms += $urandom_range(40000);
            add_random_sample(clock_ms);
        end
        settle();
        steady = 1'b0;

        configure(1'b1, 16'd0, 1'($urandom_range(1)), 8'($urandom), 16'($urandom),
                  16'($urandom));
        repeat (15) add_random_sample($urandom);
        settle();

        configure(1'b0, 16'd1, 1'b1, 8'($urandom), 16'($urandom), 16'($urandom));
        repeat (10) add_random_sample($urandom);
        settle();

        configure(1'b1, 16'd1, 1'b0, 8'($urandom), 16'($urandom), 16'($urandom));
        repeat (10) begin
            clock_ms += $urandom_range(2);
            add_random_sample(clock_ms);
        end
        settle();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
